// ===== src/cbafp_pkg.sv =====
// Package: shared types and constants for the contiguous block allocator.
package cbafp_pkg;

	localparam int NumBlocks = 64;
	localparam int NumSlots  = 8;
	localparam int BlkW      = $clog2(NumBlocks);
	localparam int CntW      = $clog2(NumBlocks + 1);
	localparam int SlotW     = $clog2(NumSlots);

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_WORST = 2'd1,
		FIT_BEST  = 2'd2,
		FIT_SPARE = 2'd3
	} fit_mode_t;

	typedef struct packed {
		logic [6:0] request_size;
		logic [3:0] request_lifetime;
	} req_t;

	typedef struct packed {
		logic       placed;
		logic [5:0] start_block;
		logic       session_end;
		logic       session_failed;
		logic [6:0] free_count;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;   // capture request, session clear if needed
		logic scan;   // examine one block position
		logic commit; // write slot, tick lifetimes, rebuild map
		logic count;  // count one occupancy bit
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic count_done;
	} dp_sts_t;

endpackage

// ===== src/cbafp_datapath.sv =====
// Datapath: slot storage, run scanner, lifetime tick and free counter.
module cbafp_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  cbafp_pkg::dp_cmd_t  cmd,
	output cbafp_pkg::dp_sts_t  sts,
	input  cbafp_pkg::req_t     req,
	input  logic [1:0]          fit_mode,
	output cbafp_pkg::res_t     res
);

	localparam int NB = cbafp_pkg::NumBlocks;
	localparam int NS = cbafp_pkg::NumSlots;

	logic [NB-1:0] slot_blocks_q [NS];
	logic [3:0]    slot_life_q [NS];
	logic [NS-1:0] slot_live_q;
	logic [NB-1:0] occ_q;
	logic [cbafp_pkg::SlotW-1:0] ctr_q;
	logic          any_fail_q;
	logic          clear_q;

	logic [6:0]    size_q;
	logic [3:0]    life_q;
	logic [cbafp_pkg::CntW-1:0] pos_q;      // scan position 0..NB
	logic [cbafp_pkg::BlkW-1:0] run_start_q;
	logic [cbafp_pkg::CntW-1:0] run_len_q;
	logic [cbafp_pkg::BlkW-1:0] best_start_q;
	logic [cbafp_pkg::CntW-1:0] best_len_q;
	logic          found_q;
	logic [cbafp_pkg::CntW-1:0] used_q;
	logic          placed_q;

	// scan step
	logic busy_b, fits, take;
	assign busy_b  = (pos_q == cbafp_pkg::CntW'(NB)) ||
		(!clear_q && occ_q[pos_q[cbafp_pkg::BlkW-1:0]]);
	assign fits = ({1'b0, run_len_q} >= {1'b0, size_q}) ;
	always_comb begin
		take = 1'b0;
		case (cbafp_pkg::fit_mode_t'(fit_mode))
			cbafp_pkg::FIT_WORST: take = run_len_q > best_len_q;
			cbafp_pkg::FIT_BEST:  take = fits && (!found_q || run_len_q < best_len_q);
			default:              take = fits && !found_q;
		endcase
	end

	// final decision
	logic found_f;
	always_comb begin
		if (fit_mode == cbafp_pkg::FIT_WORST)
			found_f = (best_len_q != '0) && ({1'b0, best_len_q} >= {1'b0, size_q});
		else
			found_f = found_q;
		found_f = found_f && (size_q != '0);
	end

	// commit: slot mask and tick
	logic [NB-1:0] mask, new_occ;
	logic [NB-1:0] nb [NS];
	logic [3:0]    nl [NS];
	logic [NS-1:0] nv;
	always_comb begin
		mask = '0;
		for (int b = 0; b < NB; b++)
			mask[b] = (b >= best_start_q) && (b < int'(best_start_q) + int'(size_q));
		new_occ = '0;
		for (int i = 0; i < NS; i++) begin
			nb[i] = clear_q ? '0 : slot_blocks_q[i];
			nl[i] = slot_life_q[i];
			nv[i] = clear_q ? 1'b0 : slot_live_q[i];
			if (ctr_q == cbafp_pkg::SlotW'(i)) begin
				nb[i] = found_f ? mask : '0;
				nl[i] = life_q;
				nv[i] = 1'b1;
			end
			if (nv[i]) begin
				if (nl[i] != 4'd0) nl[i] = nl[i] - 4'd1;
				else begin
					nb[i] = '0;
					nv[i] = 1'b0;
				end
			end
			new_occ = new_occ | nb[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_live_q <= '0;
			occ_q       <= '0;
			ctr_q       <= '0;
			any_fail_q  <= 1'b0;
			clear_q     <= 1'b0;
			for (int i = 0; i < NS; i++) begin
				slot_blocks_q[i] <= '0;
				slot_life_q[i]   <= '0;
			end
		end else if (cmd.load) begin
			clear_q <= (ctr_q == '0);
		end else if (cmd.commit) begin
			for (int i = 0; i < NS; i++) begin
				slot_blocks_q[i] <= nb[i];
				slot_life_q[i]   <= nl[i];
			end
			slot_live_q <= nv;
			occ_q       <= new_occ;
			any_fail_q  <= (clear_q ? 1'b0 : any_fail_q) | !found_f;
			clear_q     <= 1'b0;
		end else if (cmd.count && pos_q == cbafp_pkg::CntW'(NB - 1)) begin
			ctr_q <= (ctr_q == cbafp_pkg::SlotW'(NS - 1)) ? '0 : ctr_q + 1'b1;
		end
	end

	// scan and count registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			size_q     <= req.request_size;
			life_q     <= req.request_lifetime;
			pos_q      <= '0;
			run_len_q  <= '0;
			run_start_q <= '0;
			best_len_q <= '0;
			best_start_q <= '0;
			found_q    <= 1'b0;
		end else if (cmd.scan) begin
			if (!busy_b) begin
				if (run_len_q == '0) run_start_q <= pos_q[cbafp_pkg::BlkW-1:0];
				run_len_q <= run_len_q + 1'b1;
			end else begin
				if (run_len_q != '0 && take) begin
					found_q      <= (fit_mode != cbafp_pkg::FIT_WORST);
					best_len_q   <= run_len_q;
					best_start_q <= run_start_q;
				end
				run_len_q <= '0;
			end
			pos_q <= pos_q + 1'b1;
		end else if (cmd.commit) begin
			pos_q    <= '0;
			used_q   <= '0;
			placed_q <= found_f;
		end else if (cmd.count) begin
			used_q <= used_q + cbafp_pkg::CntW'(occ_q[pos_q[cbafp_pkg::BlkW-1:0]]);
			pos_q  <= pos_q + 1'b1;
		end
	end

	assign sts.scan_done  = (pos_q == cbafp_pkg::CntW'(NB));
	assign sts.count_done = (pos_q == cbafp_pkg::CntW'(NB - 1));

	// result assembled on the last count step
	logic last;
	logic [cbafp_pkg::CntW-1:0] used_f;
	assign last   = (ctr_q == cbafp_pkg::SlotW'(NS - 1));
	assign used_f = used_q + cbafp_pkg::CntW'(occ_q[pos_q[cbafp_pkg::BlkW-1:0]]);
	always_comb begin
		res.placed         = placed_q;
		res.start_block    = placed_q ? 6'(best_start_q) : 6'd0;
		res.session_end    = last;
		res.session_failed = last && any_fail_q;
		res.free_count     = 7'(cbafp_pkg::CntW'(NB) - used_f);
	end

endmodule

// ===== src/cbafp_ctrl.sv =====
// Controller: sequences load, block scan, commit and free-block count.
module cbafp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output cbafp_pkg::dp_cmd_t cmd,
	input  cbafp_pkg::dp_sts_t sts
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_COMMIT = 5'b00100,
		ST_COUNT  = 5'b01000,
		ST_SPARE  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_COUNT;
			end
			ST_COUNT: begin
				cmd.count = 1'b1;
				if (sts.count_done) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== src/contiguous_block_allocator_fit_policy.sv =====
// Top level: contiguous block allocator with first, worst and best fit.
// Sequence: from the edge that accepts start to the edge that ends the done
// cycle, 65 scan steps over the bitmap, one commit, 64 count steps.
// A new request is accepted only while busy is low, after done. The receiver
// cannot stall: done is a one-cycle strobe.
// Reset: arst_n clears all slots, the map, session counter and fit mode.
module contiguous_block_allocator_fit_policy (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  cbafp_pkg::req_t req,
	output logic            done,
	output cbafp_pkg::res_t res,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [1:0]      cfg_data
);

	cbafp_pkg::dp_cmd_t cmd;
	cbafp_pkg::dp_sts_t sts;
	logic [1:0] fit_mode_q;

	// config register transfer, only while no request is in flight
	assign cfg_ready = !busy;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fit_mode_q <= cbafp_pkg::FIT_FIRST;
		else if (cfg_valid && cfg_ready) fit_mode_q <= cfg_data;
	end

	cbafp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.done(done), .cmd(cmd), .sts(sts)
	);

	cbafp_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req(req),
		.fit_mode(fit_mode_q), .res(res)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.load, cmd.scan, cmd.commit, cmd.count}) <= 1)
		else $error("more than one datapath command");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while idle");
	a_commit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> cmd.count) else $error("commit not followed by count");
	a_place_start: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !res.placed) |-> (res.start_block == 6'd0))
		else $error("failed request with start block");

endmodule
